>>> rtl/core/upv_pkg.sv
// Shared types, constants and decode helpers for the UTF-8 password validator.
package upv_pkg;

    localparam int DATA_W   = 8;
    localparam int BYTES_W  = 12;
    localparam int POINTS_W = 10;
    localparam int COUNT_W  = 13;
    localparam int VALUE_W  = 21;
    localparam int CFG_W    = 12;
    localparam int OUT_W    = 16;

    localparam logic [BYTES_W-1:0]  MAX_BYTES_RST       = 12'd512;
    localparam logic [POINTS_W-1:0] MAX_POINTS_RST      = 10'd128;
    localparam logic [POINTS_W-1:0] MIN_POINTS_RST      = 10'd10;
    localparam logic [COUNT_W-1:0]  COUNT_SAT           = 13'h1fff;
    localparam logic [POINTS_W-1:0] POINTS_SAT          = 10'h3ff;

    typedef enum logic [1:0] {
        CFG_MAX_BYTES  = 2'd0,
        CFG_MAX_POINTS = 2'd1,
        CFG_MIN_POINTS = 2'd2
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_OK     = 4'd0,
        ST_EMPTY  = 4'd1,
        ST_BYTES  = 4'd2,
        ST_LEAD   = 4'd3,
        ST_TRUNC  = 4'd4,
        ST_CONT   = 4'd5,
        ST_SCALAR = 4'd6,
        ST_SPACE  = 4'd7,
        ST_MANY   = 4'd8,
        ST_FEW    = 4'd9
    } status_t;

    typedef struct packed {
        logic [POINTS_W-1:0] cp_total;
        status_t             status;
        logic                valid_res;
    } result_t;

    // Unicode whitespace code points that a password may not contain.
    function automatic logic is_space(input logic [VALUE_W-1:0] v);
        logic hit;
        begin
            hit = (v >= 21'h09 && v <= 21'h0d) || v == 21'h20 || v == 21'h85 ||
                  v == 21'ha0 || v == 21'h1680 || (v >= 21'h2000 && v <= 21'h200a) ||
                  v == 21'h2028 || v == 21'h2029 || v == 21'h202f ||
                  v == 21'h205f || v == 21'h3000;
            return hit;
        end
    endfunction

endpackage

>>> rtl/core/utf8_password_validator.sv
// Top level of the strict UTF-8 password validator.
//
// Usage: a string arrives on the slave stream one byte per transaction.
// s_tdata carries the byte, s_tuser says whether a byte is present and
// s_tlast ends the string; a transaction with no byte and tlast set stands
// for an empty string, and one with neither is ignored. For every
// transaction with tlast set, exactly one result transaction leaves on the
// master stream with the valid flag, the first-error status and the
// saturating code-point count.
// A string's last transaction passes the input register, then the result
// register that drives m_tvalid. Throughput is one byte per cycle unless
// stalled; a byte's decode is a single pass of small logic between the input
// register and the per-string state and result registers. The user must write
// the limits through the cfg port while the block is idle; the block does not
// enforce this. Reset loads the default limits (512 bytes, 128 and 10 code
// points) and clears all per-string state and both pipeline registers. When
// the receiver stalls, the result register holds its transaction; the input
// register still drains transactions that end no string, and s_tready drops
// only when a finished string waits behind a held result.
module utf8_password_validator
    import upv_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [DATA_W-1:0]   s_tdata,   // [7:0] data_byte
    input  logic                s_tuser,   // [0] has_byte
    input  logic                s_tlast,   // last
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_W-1:0]    m_tdata,   // [0] valid_res, [4:1] status,
                                           // [14:5] cp_total, [15] zero
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [CFG_W-1:0]    cfg_data
);

    // Limit registers.
    logic [BYTES_W-1:0]  max_bytes_reg;
    logic [POINTS_W-1:0] max_points_reg;
    logic [POINTS_W-1:0] min_points_reg;

    // Input register.
    logic              in_valid_reg;
    logic [DATA_W-1:0] in_data_reg;
    logic              in_has_reg;
    logic              in_last_reg;

    // Per-string decode state.
    logic [COUNT_W-1:0]  byte_count_reg,  byte_count_next;
    logic [1:0]          pending_reg,     pending_next;
    logic [2:0]          seq_width_reg,   seq_width_next;
    logic [VALUE_W-1:0]  partial_reg,     partial_next;
    logic [POINTS_W-1:0] points_reg,      points_next;
    status_t             error_reg,       error_next;

    // Result register.
    logic    out_valid_reg;
    result_t out_result_reg;
    result_t result_next;

    logic in_fire;
    logic stage_advance;
    logic stage_fire;

    // Code point candidate, checked before it is counted.
    logic               is_ascii;
    logic [VALUE_W-1:0] cand_value;
    logic [2:0]         cand_width;
    logic               cand_overlong;
    logic               cand_bad;
    logic               cand_space;
    logic [1:0]         pending_dec;
    status_t            end_status;

    // The item in the input register moves on unless it ends a string and
    // the result register is still held by the receiver.
    assign stage_advance = !in_last_reg || !out_valid_reg || m_tready;
    assign stage_fire    = in_valid_reg && stage_advance;
    assign s_tready      = !in_valid_reg || stage_advance;
    assign in_fire       = s_tvalid && s_tready;

    assign is_ascii    = !in_data_reg[7];
    assign pending_dec = pending_reg - 2'd1;
    assign cand_value  = is_ascii ? {{(VALUE_W-DATA_W){1'b0}}, in_data_reg}
                                  : {partial_reg[VALUE_W-7:0], in_data_reg[5:0]};
    assign cand_width  = is_ascii ? 3'd1 : seq_width_reg;

    always_comb
    begin
        cand_overlong = (cand_width == 3'd2 && cand_value < 21'h80) ||
                        (cand_width == 3'd3 && cand_value < 21'h800) ||
                        (cand_width == 3'd4 && cand_value < 21'h10000);
        cand_bad      = cand_overlong || cand_value > 21'h10ffff ||
                        (cand_value >= 21'hd800 && cand_value <= 21'hdfff);
        cand_space    = is_space(cand_value);
    end

    // One byte of decode: count, then lead or continuation handling.
    always_comb
    begin
        logic take_point;
        take_point      = 1'b0;
        byte_count_next = byte_count_reg;
        pending_next    = pending_reg;
        seq_width_next  = seq_width_reg;
        partial_next    = partial_reg;
        points_next     = points_reg;
        error_next      = error_reg;

        if (in_has_reg) begin
            if (byte_count_reg != COUNT_SAT) begin
                byte_count_next = byte_count_reg + 13'd1;
            end
            if (error_reg != ST_OK) begin
                // Decoding has stopped; a broken sequence still runs its course.
                if (error_reg == ST_CONT && pending_reg != 2'd0) begin
                    pending_next = pending_dec;
                end
            end else if (pending_reg == 2'd0) begin
                if (is_ascii) begin
                    seq_width_next = 3'd1;
                    take_point     = 1'b1;
                end else if (in_data_reg >= 8'hc2 && in_data_reg <= 8'hdf) begin
                    partial_next   = {16'd0, in_data_reg[4:0]};
                    seq_width_next = 3'd2;
                    pending_next   = 2'd1;
                end else if (in_data_reg >= 8'he0 && in_data_reg <= 8'hef) begin
                    partial_next   = {17'd0, in_data_reg[3:0]};
                    seq_width_next = 3'd3;
                    pending_next   = 2'd2;
                end else if (in_data_reg >= 8'hf0 && in_data_reg <= 8'hf4) begin
                    partial_next   = {18'd0, in_data_reg[2:0]};
                    seq_width_next = 3'd4;
                    pending_next   = 2'd3;
                end else begin
                    error_next = ST_LEAD;
                end
            end else begin
                pending_next = pending_dec;
                if (in_data_reg[7:6] != 2'b10) begin
                    error_next = ST_CONT;
                end else begin
                    partial_next = cand_value;
                    take_point   = (pending_dec == 2'd0);
                end
            end
        end

        if (take_point) begin
            if (cand_bad) begin
                error_next = ST_SCALAR;
            end else if (cand_space) begin
                error_next = ST_SPACE;
            end else begin
                // The code point over the limit is still counted.
                if (points_reg >= max_points_reg) begin
                    error_next = ST_MANY;
                end
                if (points_reg != POINTS_SAT) begin
                    points_next = points_reg + 10'd1;
                end
            end
        end

        // Verdict at the end of a string, in order of precedence.
        if (byte_count_next == '0) begin
            end_status = ST_EMPTY;
        end else if (byte_count_next > {1'b0, max_bytes_reg}) begin
            end_status = ST_BYTES;
        end else if (pending_next != 2'd0) begin
            end_status = ST_TRUNC;
        end else if (error_next != ST_OK) begin
            end_status = error_next;
        end else if (points_next < min_points_reg) begin
            end_status = ST_FEW;
        end else begin
            end_status = ST_OK;
        end

        result_next.valid_res = (end_status == ST_OK);
        result_next.status    = end_status;
        result_next.cp_total  = points_next;
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            max_bytes_reg  <= MAX_BYTES_RST;
            max_points_reg <= MAX_POINTS_RST;
            min_points_reg <= MIN_POINTS_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_MAX_BYTES:  max_bytes_reg  <= cfg_data;
                CFG_MAX_POINTS: max_points_reg <= cfg_data[POINTS_W-1:0];
                CFG_MIN_POINTS: min_points_reg <= cfg_data[POINTS_W-1:0];
                default:        ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (in_fire) begin
            in_valid_reg <= 1'b1;
        end else if (stage_advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire) begin
            in_data_reg <= s_tdata;
            in_has_reg  <= s_tuser;
            in_last_reg <= s_tlast;
        end
    end

    // Per-string state; cleared once a string has ended.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            byte_count_reg <= '0;
            pending_reg    <= '0;
            seq_width_reg  <= '0;
            partial_reg    <= '0;
            points_reg     <= '0;
            error_reg      <= ST_OK;
        end else if (stage_fire) begin
            if (in_last_reg) begin
                byte_count_reg <= '0;
                pending_reg    <= '0;
                seq_width_reg  <= '0;
                partial_reg    <= '0;
                points_reg     <= '0;
                error_reg      <= ST_OK;
            end else begin
                byte_count_reg <= byte_count_next;
                pending_reg    <= pending_next;
                seq_width_reg  <= seq_width_next;
                partial_reg    <= partial_next;
                points_reg     <= points_next;
                error_reg      <= error_next;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (stage_fire && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_fire && in_last_reg) begin
            out_result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_result_reg};

endmodule

>>> rtl/core/upv_checker.sv
// Port-level assertions for the UTF-8 password validator, bound to its top level.
module upv_checker
    import upv_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [OUT_W-1:0]    m_tdata
);

    // A held result transaction keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // The valid flag agrees with an ok status.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[0] == (m_tdata[4:1] == ST_OK)))
        else $error("valid flag disagrees with status");

    // Status codes stay within the defined set.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[4:1] <= ST_FEW))
        else $error("undefined status code");

    // An empty string decodes no code points.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[4:1] == ST_EMPTY) |-> (m_tdata[14:5] == '0))
        else $error("empty string with nonzero code point count");

endmodule

bind utf8_password_validator upv_checker u_upv_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> test/utf8_password_validator_test.sv
// Self-checking stream testbench for the strict UTF-8 password validator.
module utf8_password_validator_test
    import upv_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Half of the 4 ns clock period.
    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 8;
    // Random transactions wanted after the directed part.
    localparam int RANDOM_ITEMS = 620;
    // Transactions per random phase before the limits change.
    localparam int PHASE_ITEMS  = 110;
    // Percentage of cycles in which either side idles.
    localparam int IDLE_PCT     = 34;
    // Length of the receiver hold-off that backs the block up.
    localparam int HOLD_CYCLES  = 150;
    // Input register plus result register, with some margin. A transaction
    // that ends no string may still be in the block when the last result
    // has come, so drain() lets the block settle before any register write.
    localparam int SETTLE_CYCLES = 4;

    // One byte-stream transaction as the sender offers it.
    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic              has_byte;
        logic              last;
    } stream_item_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [DATA_W-1:0]   s_tdata = '0;    // [7:0] data_byte
    logic                s_tuser = 1'b0;  // [0] has_byte
    logic                s_tlast = 1'b0;  // last
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_W-1:0]    m_tdata;         // [0] valid_res, [4:1] status,
                                          // [14:5] cp_total, [15] zero
    logic                cfg_we = 1'b0;
    logic [1:0]          cfg_index = '0;
    logic [CFG_W-1:0]    cfg_data = '0;

    // Transactions waiting for the driver, and verdicts waiting for the block.
    stream_item_t byte_stream[$];
    result_t      verdict_q[$];

    // Limits as the predictor sees them; they track every register write.
    logic [BYTES_W-1:0]  lim_bytes = MAX_BYTES_RST;
    logic [POINTS_W-1:0] lim_most  = MAX_POINTS_RST;
    logic [POINTS_W-1:0] lim_least = MIN_POINTS_RST;

    // Per-string decode state of the predictor. ST_OK in pw_err means that
    // no error has been seen yet in the current string.
    logic [COUNT_W-1:0]  pw_bytes   = '0;
    logic [1:0]          pw_pending = '0;
    logic [2:0]          pw_width   = '0;
    logic [VALUE_W-1:0]  pw_value   = '0;
    logic [POINTS_W-1:0] pw_points  = '0;
    status_t             pw_err     = ST_OK;

    // Handshake bookkeeping shared between the clocked processes.
    bit took = 1'b0;
    bit idle_on = 1'b1;
    int hold_req = 0;
    int hold_ack = 0;
    int hold_left = 0;

    int random_items = 0;
    int failures = 0;
    int strings_checked = 0;
    int items_taken = 0;
    int input_stalls = 0;
    int settings_used = 1;
    int status_seen [10];

    // Code points the validator treats as blanks; neighbors of these are
    // also drawn so that both sides of every range boundary get exercised.
    logic [VALUE_W-1:0] blank_points [17] = '{
        21'h09, 21'h0a, 21'h0b, 21'h0c, 21'h0d, 21'h20, 21'h85, 21'ha0,
        21'h1680, 21'h2000, 21'h2005, 21'h200a, 21'h2028, 21'h2029,
        21'h202f, 21'h205f, 21'h3000
    };

    utf8_password_validator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_HALF) clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic bit is_blank_point(input logic [VALUE_W-1:0] v);
        return v inside {[21'h09:21'h0d], 21'h20, 21'h85, 21'ha0, 21'h1680,
                         [21'h2000:21'h200a], 21'h2028, 21'h2029, 21'h202f,
                         21'h205f, 21'h3000};
    endfunction

    // A completed code point: reject overlong forms, out-of-range values,
    // surrogates and blanks, otherwise count it against the upper limit.
    function automatic void settle_point(input logic [VALUE_W-1:0] v);
        bit overlong;
        overlong = (pw_width == 3'd2 && v < 21'h80) ||
                   (pw_width == 3'd3 && v < 21'h800) ||
                   (pw_width == 3'd4 && v < 21'h10000);
        if (overlong || v > 21'h10ffff || (v >= 21'hd800 && v <= 21'hdfff))
            pw_err = ST_SCALAR;
        else if (is_blank_point(v))
            pw_err = ST_SPACE;
        else
        begin
            // The point that breaks the upper limit is still counted.
            if (pw_points >= lim_most)
                pw_err = ST_MANY;
            if (pw_points != POINTS_SAT)
                pw_points = pw_points + 10'd1;
        end
    endfunction

    function automatic void decode_byte(input logic [DATA_W-1:0] b);
        if (pw_err != ST_OK)
        begin
            // Once a string has failed, bytes are no longer decoded. Only a
            // broken continuation keeps counting down its sequence so that
            // a string ending inside it still reads as truncated.
            if (pw_err == ST_CONT && pw_pending != 2'd0)
                pw_pending = pw_pending - 2'd1;
        end
        else if (pw_pending == 2'd0)
        begin
            if (b < 8'h80)
            begin
                pw_width = 3'd1;
                settle_point({13'd0, b});
            end
            else if (b >= 8'hc2 && b <= 8'hdf)
            begin
                pw_value   = {16'd0, b[4:0]};
                pw_width   = 3'd2;
                pw_pending = 2'd1;
            end
            else if (b >= 8'he0 && b <= 8'hef)
            begin
                pw_value   = {17'd0, b[3:0]};
                pw_width   = 3'd3;
                pw_pending = 2'd2;
            end
            else if (b >= 8'hf0 && b <= 8'hf4)
            begin
                pw_value   = {18'd0, b[2:0]};
                pw_width   = 3'd4;
                pw_pending = 2'd3;
            end
            else
                pw_err = ST_LEAD;
        end
        else
        begin
            pw_pending = pw_pending - 2'd1;
            if (b[7:6] != 2'b10)
                pw_err = ST_CONT;
            else
            begin
                pw_value = {pw_value[VALUE_W-7:0], b[5:0]};
                if (pw_pending == 2'd0)
                    settle_point(pw_value);
            end
        end
    endfunction

    // Applies one accepted transaction; a transaction with last set yields
    // the verdict for the whole string and clears the per-string state.
    function automatic void grade_item(input logic [DATA_W-1:0] b, input logic has,
                                       input logic fin);
        status_t st;
        result_t verdict;
        if (has)
        begin
            if (pw_bytes != COUNT_SAT)
                pw_bytes = pw_bytes + 13'd1;
            decode_byte(b);
        end
        if (fin)
        begin
            if (pw_bytes == '0)
                st = ST_EMPTY;
            else if (pw_bytes > {1'b0, lim_bytes})
                st = ST_BYTES;
            else if (pw_pending != 2'd0)
                st = ST_TRUNC;
            else if (pw_err != ST_OK)
                st = pw_err;
            else if (pw_points < lim_least)
                st = ST_FEW;
            else
                st = ST_OK;
            verdict.valid_res = (st == ST_OK);
            verdict.status    = st;
            verdict.cp_total  = pw_points;
            verdict_q.push_back(verdict);
            pw_bytes   = '0;
            pw_pending = '0;
            pw_width   = '0;
            pw_value   = '0;
            pw_points  = '0;
            pw_err     = ST_OK;
        end
    endfunction

    // ------------------------------------------------------------------
    // Clocked processes
    // ------------------------------------------------------------------

    // Acceptance is sampled at the rising edge, before the block updates
    // s_tready, so every accepted transaction feeds the predictor in order.
    always @(posedge clk)
    begin : intake
        took = rst_n && s_tvalid && s_tready;
        if (took)
        begin
            items_taken++;
            grade_item(s_tdata, s_tuser, s_tlast);
        end
        if (rst_n && s_tvalid && !s_tready)
            input_stalls++;
    end

    // The driver changes the slave-side inputs only on the falling edge. An
    // offered transaction stays on the bus until the block takes it.
    always @(negedge clk)
    begin : driver
        stream_item_t nxt;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (s_tvalid && !took)
        begin
            // Still waiting for the block; hold the offer unchanged.
        end
        else if (byte_stream.size() == 0 ||
                 (idle_on && $urandom_range(0, 99) < IDLE_PCT))
            s_tvalid <= 1'b0;
        else
        begin
            nxt = byte_stream.pop_front();
            s_tvalid <= 1'b1;
            s_tdata  <= nxt.data_byte;
            s_tuser  <= nxt.has_byte;
            s_tlast  <= nxt.last;
        end
    end

    // The receiver stalls at random, and on request holds m_tready low for a
    // long, counted stretch so that results back up into the block.
    always @(negedge clk)
    begin : receiver
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left != 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (hold_req != hold_ack)
        begin
            hold_ack  = hold_req;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else
            m_tready <= !(idle_on && $urandom_range(0, 99) < IDLE_PCT);
    end

    // Every result transaction is checked against the oldest verdict.
    always @(posedge clk)
    begin : monitor
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = result_t'(m_tdata[14:0]);
            if (verdict_q.size() == 0)
            begin
                $error("result transaction with no string pending: m_tdata %h", m_tdata);
                failures++;
            end
            else
            begin
                want = verdict_q.pop_front();
                strings_checked++;
                status_seen[want.status]++;
                if (got.valid_res !== want.valid_res)
                begin
                    $error("valid_res: expected %0d, got %0d", want.valid_res, got.valid_res);
                    failures++;
                end
                if (got.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    failures++;
                end
                if (got.cp_total !== want.cp_total)
                begin
                    $error("cp_total: expected %0d, got %0d",
                           want.cp_total, got.cp_total);
                    failures++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic void push_item(input logic [DATA_W-1:0] b, input logic has,
                                      input logic fin, input bit counted);
        stream_item_t it;
        it.data_byte = b;
        it.has_byte  = has;
        it.last      = fin;
        byte_stream.push_back(it);
        if (counted && (has || fin))
            random_items++;
    endfunction

    // Queues one string. The end is marked either on its final byte or by a
    // separate transaction with no byte; an empty string always uses the
    // latter. Transactions that the block ignores are sprinkled in between.
    function automatic void send_string(input logic [DATA_W-1:0] text[$], input bit marker,
                                        input bit counted);
        if (text.size() == 0)
            marker = 1'b1;
        foreach (text[i])
        begin
            if ($urandom_range(0, 99) < 4)
                push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
            push_item(text[i], 1'b1, !marker && i == text.size() - 1, counted);
        end
        if (marker)
            push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, counted);
    endfunction

    function automatic logic [DATA_W-1:0] cont_byte();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    function automatic void append_point(ref logic [DATA_W-1:0] text[$],
                                         input logic [VALUE_W-1:0] cp);
        if (cp < 21'h80)
            text.push_back(cp[7:0]);
        else if (cp < 21'h800)
        begin
            text.push_back({3'b110, cp[10:6]});
            text.push_back({2'b10, cp[5:0]});
        end
        else if (cp < 21'h10000)
        begin
            text.push_back({4'b1110, cp[15:12]});
            text.push_back({2'b10, cp[11:6]});
            text.push_back({2'b10, cp[5:0]});
        end
        else
        begin
            text.push_back({5'b11110, cp[20:18]});
            text.push_back({2'b10, cp[17:12]});
            text.push_back({2'b10, cp[11:6]});
            text.push_back({2'b10, cp[5:0]});
        end
    endfunction

    // Mostly printable ASCII and well-formed multi-byte points, with a few
    // control characters and now and then a blank or one of its neighbors.
    function automatic logic [VALUE_W-1:0] pick_point();
        int unsigned r;
        logic [VALUE_W-1:0] v;
        r = $urandom_range(0, 99);
        if (r < 41)
            v = 21'($urandom_range(8'h21, 8'h7e));
        else if (r < 49)
        begin
            v = ($urandom_range(0, 3) == 0) ? 21'h7f : 21'($urandom_range(0, 31));
            if (is_blank_point(v))
                v = 21'h1f;
        end
        else if (r < 64)
            v = 21'($urandom_range(21'h80, 21'h7ff));
        else if (r < 81)
        begin
            v = 21'($urandom_range(21'h800, 21'hffff));
            if (v >= 21'hd800 && v <= 21'hdfff)
                v = v ^ 21'h4000;
        end
        else if (r < 98)
            v = 21'($urandom_range(21'h10000, 21'h10ffff));
        else
        begin
            v = blank_points[$urandom_range(0, 16)];
            case ($urandom_range(0, 3))
                0: v = v + 21'd1;
                1: v = v - 21'd1;
                default: ;
            endcase
        end
        return v;
    endfunction

    // Appends one malformed sequence. A cut-off sequence has to end the
    // string, which the caller learns through ends.
    function automatic void append_fault(ref logic [DATA_W-1:0] text[$], output bit ends);
        int w;
        logic [DATA_W-1:0] lead;
        ends = 1'b0;
        w = $urandom_range(2, 4);
        case (w)
            2: lead = 8'($urandom_range(8'hc2, 8'hdf));
            3: lead = 8'($urandom_range(8'he1, 8'hec));
            default: lead = 8'($urandom_range(8'hf1, 8'hf3));
        endcase
        case ($urandom_range(0, 6))
            0:
            begin
                // A stray continuation, C0/C1 or a lead above F4.
                if ($urandom_range(0, 1) != 0)
                    text.push_back(8'($urandom_range(8'h80, 8'hc1)));
                else
                    text.push_back(8'($urandom_range(8'hf5, 8'hff)));
            end
            1:
            begin
                text.push_back(lead);
                repeat ($urandom_range(0, w - 2))
                    text.push_back(cont_byte());
                ends = 1'b1;
            end
            2:
            begin
                text.push_back(lead);
                repeat ($urandom_range(0, w - 2))
                    text.push_back(cont_byte());
                if ($urandom_range(0, 1) != 0)
                    text.push_back(8'($urandom_range(0, 8'h7f)));
                else
                    text.push_back(8'($urandom_range(8'hc0, 8'hff)));
            end
            3:
            begin
                // Surrogate half.
                text.push_back(8'hed);
                text.push_back(8'($urandom_range(8'ha0, 8'hbf)));
                text.push_back(cont_byte());
            end
            4:
            begin
                // Overlong three- or four-byte form.
                if ($urandom_range(0, 1) != 0)
                begin
                    text.push_back(8'he0);
                    text.push_back(8'($urandom_range(8'h80, 8'h9f)));
                end
                else
                begin
                    text.push_back(8'hf0);
                    text.push_back(8'($urandom_range(8'h80, 8'h8f)));
                    text.push_back(cont_byte());
                end
                text.push_back(cont_byte());
            end
            5:
            begin
                // Beyond the last scalar value.
                text.push_back(8'hf4);
                text.push_back(8'($urandom_range(8'h90, 8'hbf)));
                text.push_back(cont_byte());
                text.push_back(cont_byte());
            end
            default: append_point(text, blank_points[$urandom_range(0, 16)]);
        endcase
    endfunction

    // One random string: mostly well-formed passwords of random content,
    // some with one fault planted at a random place, some raw byte noise
    // and some empty strings.
    function automatic void add_random_password();
        logic [DATA_W-1:0] text[$];
        int unsigned kind;
        int n;
        int fault_at;
        bit stop;
        kind = $urandom_range(0, 99);
        stop = 1'b0;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 140) : $urandom_range(0, 14);
        fault_at = (kind >= 68 && kind < 84) ? $urandom_range(0, n) : -1;
        if (kind < 84)
        begin
            for (int i = 0; i <= n && !stop; i++)
            begin
                if (i == fault_at)
                    append_fault(text, stop);
                if (!stop && i < n)
                    append_point(text, pick_point());
            end
        end
        else if (kind < 94)
        begin
            repeat ($urandom_range(1, 12))
                text.push_back(8'($urandom_range(0, 255)));
        end
        send_string(text, $urandom_range(0, 99) < 30, 1'b1);
    endfunction

    // A run of printable ASCII of the given length.
    function automatic void send_plain(input int n);
        logic [DATA_W-1:0] text[$];
        repeat (n)
            text.push_back(8'($urandom_range(8'h21, 8'h7e)));
        send_string(text, 1'b0, 1'b0);
    endfunction

    // Register writes happen only with the block idle, so the predictor
    // copy can change at the same moment.
    task automatic set_limits(input logic [BYTES_W-1:0] bytes_lim,
                              input logic [POINTS_W-1:0] most, input logic [POINTS_W-1:0] least);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MAX_BYTES;
        cfg_data  <= bytes_lim;
        lim_bytes = bytes_lim;
        @(negedge clk);
        cfg_index <= CFG_MAX_POINTS;
        cfg_data  <= {2'b00, most};
        lim_most = most;
        @(negedge clk);
        cfg_index <= CFG_MIN_POINTS;
        cfg_data  <= {2'b00, least};
        lim_least = least;
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // The sender stays quiet until every queued transaction is taken and
    // every verdict has arrived, then lets the block settle.
    task automatic drain();
        do
            @(negedge clk);
        while (byte_stream.size() != 0 || s_tvalid || verdict_q.size() != 0);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial
    begin : stimulus
        int phase;
        int phase_start;
        logic [DATA_W-1:0] one[$];

        repeat (RESET_CYCLES)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at the reset limits: an empty string, and a short
        // string that falls below the default lower limit of ten points.
        one.delete();
        send_string(one, 1'b1, 1'b0);
        send_string('{8'h61}, 1'b0, 1'b0);
        drain();

        // Tight limits so that eight statuses show up within a few bytes:
        // the ASCII extremes, the greatest scalar, too many points, a
        // surrogate, an ideographic space, a C0 lead ended by a marker,
        // a broken continuation, a cut-off sequence and too many bytes.
        set_limits(12'd4, 10'd2, 10'd0);
        send_string('{8'h00, 8'h7f}, 1'b0, 1'b0);
        send_string('{8'h41, 8'h42, 8'h43}, 1'b0, 1'b0);
        send_string('{8'hf4, 8'h8f, 8'hbf, 8'hbf}, 1'b0, 1'b0);
        send_string('{8'hed, 8'ha0, 8'h80}, 1'b0, 1'b0);
        send_string('{8'he3, 8'h80, 8'h80}, 1'b0, 1'b0);
        send_string('{8'hc0}, 1'b1, 1'b0);
        send_string('{8'hc3, 8'h41}, 1'b0, 1'b0);
        send_string('{8'he2}, 1'b0, 1'b0);
        send_string('{8'hff, 8'hfe, 8'h00, 8'h01, 8'h02}, 1'b0, 1'b0);
        drain();

        // Random phases, each under its own set of limits. The first few
        // cover the defaults, the widest limits, the pressure test and the
        // smallest and out-of-range limits; later ones are random and kept
        // small so that the limits actually decide many verdicts.
        phase = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            phase_start = random_items;
            case (phase)
                0: set_limits(MAX_BYTES_RST, MAX_POINTS_RST, MIN_POINTS_RST);
                1:
                begin
                    // No idling on either side for this whole phase.
                    set_limits(12'hfff, 10'h3ff, 10'h000);
                    idle_on = 1'b0;
                end
                2:
                begin
                    // The receiver holds off while a burst of short strings
                    // arrives, so the block fills and stalls its input.
                    set_limits(12'd8, 10'd3, 10'd1);
                    hold_req++;
                    for (int i = 0; i < 24; i++)
                    begin
                        one.delete();
                        if (i % 2 != 0)
                            one.push_back(8'($urandom_range(8'h21, 8'h7e)));
                        send_string(one, 1'b0, 1'b1);
                    end
                end
                3: set_limits(12'd1, 10'd1, 10'd0);
                4: set_limits(12'd0, 10'd0, 10'd0);
                default: set_limits(12'($urandom_range(1, 48)), 10'($urandom_range(1, 16)),
                                    10'($urandom_range(0, 6)));
            endcase
            while (random_items - phase_start < PHASE_ITEMS)
                add_random_password();
            drain();
            idle_on = 1'b1;
            phase++;
        end

        // Limits that meet: exactly the most points passes, one more point
        // breaks the upper limit, and a string past the byte limit fails.
        set_limits(12'd24, 10'd20, 10'd20);
        send_plain(20);
        send_plain(21);
        send_plain(25);
        drain();

        $display("Checked %0d strings, %0d transactions, %0d limit sets, %0d input stalls.",
                 strings_checked, items_taken, settings_used, input_stalls);
        $display("Statuses ok..few: %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], status_seen[5], status_seen[6], status_seen[7],
                 status_seen[8], status_seen[9]);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Far beyond the slowest correct run; reaching it means the block hung.
    initial
    begin : watchdog
        #2_000_000;
        $display("Timed out with %0d verdicts outstanding.", verdict_q.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/upv_pkg.sv
rtl/core/utf8_password_validator.sv
rtl/core/upv_checker.sv
test/utf8_password_validator_test.sv
